// ===== sv/cvw_pkg.sv =====
// Shared types and constants for the 3x3 valid-padding convolution block.
`default_nettype none

package cvw_pkg;

  localparam int KERNEL_W    = 3;
  localparam int KERNEL_H    = 3;
  localparam int KERNEL_TAPS = KERNEL_W * KERNEL_H;
  localparam int WEIGHT_BITS = 16;
  localparam int DIM_BITS    = 11;
  localparam int COORD_BITS  = 10;
  localparam int SUM_BITS    = 36;
  localparam int CFG_BITS    = 64;
  localparam int MAX_HEIGHT  = 1024;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_WEIGHTS_LOW  = 3'd2,
    CFG_WEIGHTS_MID  = 3'd3,
    CFG_WEIGHT_LAST  = 3'd4
  } cfg_reg_t;

  // Coordinates and frame mark that travel with an item down the pipe
  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  frame_end;
  } cvw_tag_t;

endpackage

`default_nettype wire

// ===== sv/conv2d_valid_window.sv =====
// A result passes stage B, the product, row-sum and output registers.
// Throughput: one sample per cycle unless stalled; the line store reads and
// writes one packed two-row word per cycle; nine multipliers work in parallel.
// Reset clears counters, window, pipeline valids and configuration (width and
// height 1024, weights zero); the line store is not cleared.
// Results start once the window covers three full rows and columns.
`default_nettype none

module conv2d_valid_window #(
  parameter int MAX_IMAGE_WIDTH = 1024,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [cvw_pkg::SUM_BITS-1:0]       out_conv_sum,
  output logic        [cvw_pkg::COORD_BITS-1:0]     out_col,
  output logic        [cvw_pkg::COORD_BITS-1:0]     out_row,
  output logic                                      out_frame_end,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [2:0]                           cfg_index,
  input  wire logic [cvw_pkg::CFG_BITS-1:0]         cfg_data
);

  localparam int CW = $clog2(MAX_IMAGE_WIDTH);
  localparam int WW = CW + 1;
  localparam int DB = cvw_pkg::DIM_BITS;
  localparam int WB = cvw_pkg::WEIGHT_BITS;

  // Configuration
  logic [DB-1:0]                image_width_r;
  logic [DB-1:0]                image_height_r;
  logic [cvw_pkg::CFG_BITS-1:0] weights_low_r;
  logic [cvw_pkg::CFG_BITS-1:0] weights_mid_r;
  logic [WB-1:0]                weight_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DB'(1024);
      image_height_r <= DB'(1024);
      weights_low_r  <= '0;
      weights_mid_r  <= '0;
      weight_last_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cvw_pkg::cfg_reg_t'(cfg_index))
        cvw_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DB-1:0];
        cvw_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[DB-1:0];
        cvw_pkg::CFG_WEIGHTS_LOW:  weights_low_r  <= cfg_data;
        cvw_pkg::CFG_WEIGHTS_MID:  weights_mid_r  <= cfg_data;
        cvw_pkg::CFG_WEIGHT_LAST:  weight_last_r  <= cfg_data[WB-1:0];
        default: ;
      endcase
    end
  end

  cvw_pkg::weight_t weights [cvw_pkg::KERNEL_TAPS];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      weights[k]     = weights_low_r[WB*k +: WB];
      weights[k + 4] = weights_mid_r[WB*k +: WB];
    end
    weights[8] = weight_last_r;
  end

  // Saturate dimensions into their legal ranges
  logic [WW-1:0] w_lim;
  logic [DB-1:0] h_lim;

  always_comb begin
    if (32'(image_width_r) < cvw_pkg::KERNEL_W) begin
      w_lim = WW'(cvw_pkg::KERNEL_W);
    end else if (32'(image_width_r) > MAX_IMAGE_WIDTH) begin
      w_lim = WW'(MAX_IMAGE_WIDTH);
    end else begin
      w_lim = WW'(image_width_r);
    end
    if (32'(image_height_r) < cvw_pkg::KERNEL_H) begin
      h_lim = DB'(cvw_pkg::KERNEL_H);
    end else if (32'(image_height_r) > cvw_pkg::MAX_HEIGHT) begin
      h_lim = DB'(cvw_pkg::MAX_HEIGHT);
    end else begin
      h_lim = image_height_r;
    end
  end

  // Raster position of the next sample
  logic [CW-1:0]                  col_r, col_nxt;
  logic [cvw_pkg::COORD_BITS-1:0] row_r, row_nxt;
  logic [WW-1:0]                  col_inc;
  logic [DB-1:0]                  row_inc;
  logic                           accept;
  logic                           produce;
  cvw_pkg::cvw_tag_t              tag_in;

  assign col_inc = WW'(col_r) + WW'(1);
  assign row_inc = DB'(row_r) + DB'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= w_lim) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_lim) ? '0 : cvw_pkg::COORD_BITS'(row_inc);
    end else begin
      col_nxt = CW'(col_inc);
    end
  end

  assign produce = (32'(row_r) >= cvw_pkg::KERNEL_H - 1) && (DB'(row_r) < h_lim) &&
                   (32'(col_r) >= cvw_pkg::KERNEL_W - 1) && (WW'(col_r) < w_lim);

  assign tag_in.col       = cvw_pkg::COORD_BITS'(32'(col_r) - (cvw_pkg::KERNEL_W - 1));
  assign tag_in.row       = cvw_pkg::COORD_BITS'(32'(row_r) - (cvw_pkg::KERNEL_H - 1));
  assign tag_in.frame_end = (row_inc == h_lim) && (col_inc == w_lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage B: line store data arrives, window shifts
  logic                          valid_b_r;
  logic                          produce_b_r;
  logic signed [SAMPLE_BITS-1:0] sample_b_r;
  logic [CW-1:0]                 addr_b_r;
  cvw_pkg::cvw_tag_t             tag_b_r;
  logic                          mac_free;
  logic                          go_b;
  logic                          free_b;

  assign go_b     = valid_b_r && (!produce_b_r || mac_free);
  assign free_b   = !valid_b_r || go_b;
  assign accept   = in_valid && free_b;
  assign in_stall = !free_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (free_b) begin
      valid_b_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      produce_b_r <= produce;
      sample_b_r  <= in_sample;
      addr_b_r    <= col_r;
      tag_b_r     <= tag_in;
    end
  end

  logic [2*SAMPLE_BITS-1:0] line_rd;
  logic [2*SAMPLE_BITS-1:0] line_wr;
  logic signed [SAMPLE_BITS-1:0] colv [cvw_pkg::KERNEL_H];

  assign colv[0] = line_rd[SAMPLE_BITS-1:0];
  assign colv[1] = line_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign colv[2] = sample_b_r;
  // Shift the column up one row: the upper row takes the old lower row
  assign line_wr = {sample_b_r, line_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]};

  cvw_line_store #(
    .DEPTH     (MAX_IMAGE_WIDTH),
    .WORD_BITS (2 * SAMPLE_BITS)
  ) u_line (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (line_rd),
    .wr_en   (go_b),
    .wr_addr (addr_b_r),
    .wr_data (line_wr)
  );

  // Window: taps in row-major order, newest column on the right
  logic signed [SAMPLE_BITS-1:0] win_r   [cvw_pkg::KERNEL_TAPS];
  logic signed [SAMPLE_BITS-1:0] win_nxt [cvw_pkg::KERNEL_TAPS];

  always_comb begin
    for (int r = 0; r < cvw_pkg::KERNEL_H; r++) begin
      win_nxt[3*r]     = win_r[3*r + 1];
      win_nxt[3*r + 1] = win_r[3*r + 2];
      win_nxt[3*r + 2] = colv[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < cvw_pkg::KERNEL_TAPS; k++) begin
        win_r[k] <= '0;
      end
    end else if (go_b) begin
      win_r <= win_nxt;
    end
  end

  cvw_pkg::cvw_tag_t res_tag;

  cvw_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go_b && produce_b_r),
    .win       (win_nxt),
    .weights   (weights),
    .tag       (tag_b_r),
    .free      (mac_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .conv_sum  (out_conv_sum),
    .out_tag   (res_tag)
  );

  assign out_col       = res_tag.col;
  assign out_row       = res_tag.row;
  assign out_frame_end = res_tag.frame_end;

  // An empty window stage never holds off the source
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_b_r |-> !in_stall)
    else $error("input stalled with an empty window stage");

  // Consecutive samples never share a line store column
  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && go_b) |-> (col_r != addr_b_r))
    else $error("line store read and write hit the same column");

  // Column wraps to zero at the end of a row
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (col_inc >= w_lim)) |=> (col_r == '0))
    else $error("column counter failed to wrap");

  // Stage B keeps its item until it hands it on, the only time the window moves
  a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_b_r && !go_b) |=> $stable(addr_b_r))
    else $error("window stage item changed while held");

endmodule

`default_nettype wire

// ===== sv/cvw_line_store.sv =====
// Line buffer memory: two source rows packed per word, registered read.
`default_nettype none

module cvw_line_store #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WORD_BITS-1:0]     rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WORD_BITS-1:0]     wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Forward a same-cycle write so a read never sees a stale entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/cvw_mac.sv =====
// Nine-tap multiply and adder tree with the result output register.
`default_nettype none

module cvw_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic signed [SAMPLE_BITS-1:0] win [cvw_pkg::KERNEL_TAPS],
  input  wire cvw_pkg::weight_t              weights [cvw_pkg::KERNEL_TAPS],
  input  wire cvw_pkg::cvw_tag_t             tag,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [cvw_pkg::SUM_BITS-1:0] conv_sum,
  output cvw_pkg::cvw_tag_t                  out_tag
);

  localparam int PB  = SAMPLE_BITS + cvw_pkg::WEIGHT_BITS;
  localparam int PSW = PB + 2;
  localparam int SW  = PB + 4;

  logic                 valid_c_r;
  logic signed [PB-1:0] prod_r [cvw_pkg::KERNEL_TAPS];
  cvw_pkg::cvw_tag_t    tag_c_r;

  logic                  valid_d_r;
  logic signed [PSW-1:0] psum_r [cvw_pkg::KERNEL_H];
  cvw_pkg::cvw_tag_t     tag_d_r;

  logic                                out_valid_r;
  logic signed [cvw_pkg::SUM_BITS-1:0] conv_sum_r;
  cvw_pkg::cvw_tag_t                   tag_o_r;

  logic signed [SW-1:0] total;
  logic go_d, free_d, go_c, free_c;

  assign go_d   = valid_d_r && (!out_valid_r || !out_stall);
  assign free_d = !valid_d_r || go_d;
  assign go_c   = valid_c_r && free_d;
  assign free_c = !valid_c_r || go_c;
  assign free   = free_c;

  assign total = SW'(psum_r[0]) + SW'(psum_r[1]) + SW'(psum_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_c_r   <= 1'b0;
      valid_d_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free_c) begin
        valid_c_r <= load;
      end
      if (free_d) begin
        valid_d_r <= go_c;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= go_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && free_c) begin
      for (int k = 0; k < cvw_pkg::KERNEL_TAPS; k++) begin
        prod_r[k] <= PB'(win[k]) * PB'(weights[k]);
      end
      tag_c_r <= tag;
    end
    if (go_c) begin
      for (int i = 0; i < cvw_pkg::KERNEL_H; i++) begin
        psum_r[i] <= PSW'(prod_r[3*i]) + PSW'(prod_r[3*i+1]) + PSW'(prod_r[3*i+2]);
      end
      tag_d_r <= tag_c_r;
    end
    if (go_d) begin
      conv_sum_r <= cvw_pkg::SUM_BITS'(total);
      tag_o_r    <= tag_d_r;
    end
  end

  assign out_valid = out_valid_r;
  assign conv_sum  = conv_sum_r;
  assign out_tag   = tag_o_r;

  // A product row held back by the tree must keep its tag
  a_hold_c: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_c_r && !free_d) |=> (valid_c_r && $stable(tag_c_r)))
    else $error("product stage lost its item while held");

  // The tree never advances into a full output register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !go_d)
    else $error("adder tree overran a stalled result");

endmodule

`default_nettype wire
